>>> hw/rtl/weighted_3x3_smoothing_filter_macros.svh
// Assertion helpers shared by the filter RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef WEIGHTED_3X3_SMOOTHING_FILTER_MACROS_SVH
`define WEIGHTED_3X3_SMOOTHING_FILTER_MACROS_SVH

// Same-cycle implication.
`define W3SF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define W3SF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/w3sf_pkg.sv
package w3sf_pkg;

  // Longest row the line store can hold.
  localparam int MAX_WIDTH = 64;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LEVEL_W   = 8;
  localparam int ROW_W     = 12;
  localparam int WIDTH_W   = 7;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST  = 7'd36;
  localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST = 12'd36;
  localparam int MIN_DIM = 3;

  typedef logic [COL_W-1:0]   col_t;
  typedef logic [COL_W:0]     colp_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    level_t level_in;
    logic   frame_start;
  } in_item_t;

  typedef struct packed {
    level_t smoothed_level;
    logic   last_of_frame;
  } out_item_t;

  // New window column: two rows back, one row back, current row.
  typedef struct packed {
    level_t top;
    level_t mid;
    level_t bot;
  } win_col_t;

  // Item held while its line store read completes.
  typedef struct packed {
    level_t level;
    col_t   col;
    logic   produce;
    logic   frame_end;
  } stage_t;

  // Row length clamped to the range the line store supports.
  function automatic colp_t eff_width(logic [WIDTH_W-1:0] w);
    colp_t r;
    if (w < WIDTH_W'(MIN_DIM)) begin
      r = colp_t'(MIN_DIM);
    end else if (int'(w) > MAX_WIDTH) begin
      r = colp_t'(MAX_WIDTH);
    end else begin
      r = colp_t'(w);
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/w3sf_ram.sv
module w3sf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/w3sf_window.sv
module w3sf_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  w3sf_pkg::win_col_t  col_i,
  output w3sf_pkg::level_t    level_o
);

  w3sf_pkg::level_t win_q [3][3];
  w3sf_pkg::level_t win_d [3][3];
  logic [9:0]       acc;

  // Rows are top, middle, bottom; column 2 is the newest.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        win_d[r][c] = win_q[r][c];
      end
    end
    if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[0][2] = col_i.top;
      win_d[1][2] = col_i.mid;
      win_d[2][2] = col_i.bot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
    end
  end

  // Each neighbor term is truncated on its own before the sum.
  assign acc = 10'(win_d[1][1])
             + 10'(win_d[0][1] >> 1) + 10'(win_d[2][1] >> 1)
             + 10'(win_d[1][0] >> 1) + 10'(win_d[1][2] >> 1)
             + 10'(win_d[0][0] >> 2) + 10'(win_d[0][2] >> 2)
             + 10'(win_d[2][0] >> 2) + 10'(win_d[2][2] >> 2);

  assign level_o = acc[9:2];

endmodule

>>> hw/rtl/weighted_3x3_smoothing_filter.sv
// Weighted 3x3 smoothing filter. Samples stream in raster order, image_width
// per row and image_height rows per frame, border included; a set frame_start
// restarts the position counters at that sample. Once a sample completes a
// window lying wholly inside the frame, one transaction leaves the output
// with (center + sum(edge >> 1) + sum(corner >> 2)) >> 2 for the window
// centered one row and one column back, and last_of_frame marks the result
// made by the frame's final sample. The block takes one transaction per
// clock cycle. The only thing that slows it is the output side: while a
// result waits in a stalled output register, a held sample that owes a
// result cannot move on, and the input stalls until it does. An accepted
// sample is registered in the read stage while the line store is read (a
// 64 x 16 RAM with one read port and one write port, holding the previous
// two rows per column), and its result is then registered in the output
// register. Configuration writes belong to idle periods; the line store
// needs no clearing after reset.
`include "weighted_3x3_smoothing_filter_macros.svh"

module weighted_3x3_smoothing_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [w3sf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [w3sf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  w3sf_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output w3sf_pkg::out_item_t                 out_data_o
);

  localparam int PAIR_W = 2 * w3sf_pkg::LEVEL_W;

  // Configuration registers.
  logic [w3sf_pkg::WIDTH_W-1:0]  image_width_q;
  logic [w3sf_pkg::HEIGHT_W-1:0] image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= w3sf_pkg::IMAGE_WIDTH_RST;
      image_height_q <= w3sf_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        w3sf_pkg::CFG_IMAGE_WIDTH: begin
          image_width_q <= cfg_wdata_i[w3sf_pkg::WIDTH_W-1:0];
        end
        w3sf_pkg::CFG_IMAGE_HEIGHT: begin
          image_height_q <= cfg_wdata_i[w3sf_pkg::HEIGHT_W-1:0];
        end
      endcase
    end
  end

  // Effective frame geometry.
  w3sf_pkg::colp_t w_eff;
  w3sf_pkg::row_t  h_eff;

  assign w_eff = w3sf_pkg::eff_width(image_width_q);
  assign h_eff = (image_height_q < w3sf_pkg::HEIGHT_W'(w3sf_pkg::MIN_DIM))
               ? w3sf_pkg::row_t'(w3sf_pkg::MIN_DIM) : image_height_q;

  // Pipeline handshake. The held stage moves on unless it carries a result
  // and the output register is full and stalled.
  w3sf_pkg::stage_t s1_q, s1_d;
  logic             s1_valid_q;
  logic             s1_adv;
  logic             in_ready;
  logic             in_accept;
  logic             out_valid_q;
  w3sf_pkg::out_item_t out_q;

  assign s1_adv    = s1_valid_q && (!s1_q.produce || !out_valid_q || !out_stall_i);
  assign in_ready  = !s1_valid_q || s1_adv;
  assign in_accept = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  // Position counters; frame_start clears them before the sample is placed.
  w3sf_pkg::col_t column_count_q, column_count_d;
  w3sf_pkg::row_t row_count_q, row_count_d;
  w3sf_pkg::col_t col_cur;
  w3sf_pkg::row_t row_cur;
  logic           row_end;
  logic           frame_end;

  assign col_cur = in_data_i.frame_start ? '0 : column_count_q;
  assign row_cur = in_data_i.frame_start ? '0 : row_count_q;

  assign row_end   = (w3sf_pkg::colp_t'(col_cur) + 1'b1) >= w_eff;
  assign frame_end = row_end
                   && ({1'b0, row_cur} + 1'b1) >= {1'b0, h_eff};

  always_comb begin
    if (row_end) begin
      column_count_d = '0;
      row_count_d    = frame_end ? '0 : row_cur + 1'b1;
    end else begin
      column_count_d = col_cur + 1'b1;
      row_count_d    = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      row_count_q    <= '0;
    end else if (in_accept) begin
      column_count_q <= column_count_d;
      row_count_q    <= row_count_d;
    end
  end

  always_comb begin
    s1_d.level     = in_data_i.level_in;
    s1_d.col       = col_cur;
    s1_d.produce   = (col_cur >= w3sf_pkg::col_t'(2)) && (row_cur >= w3sf_pkg::row_t'(2));
    s1_d.frame_end = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= s1_d;
    end
  end

  // Line store: per column, the upper byte holds the row two back and the
  // lower byte the row one back. It is written when the held sample moves
  // on, so a read issued on that same edge at the same column is served by
  // the bypass register instead of the RAM.
  logic [PAIR_W-1:0] ram_rdata;
  logic [PAIR_W-1:0] ram_wdata;
  logic [PAIR_W-1:0] up_pair;
  logic [PAIR_W-1:0] byp_data_q;
  logic              byp_q;
  logic              byp_d;

  assign up_pair   = byp_q ? byp_data_q : ram_rdata;
  assign ram_wdata = {up_pair[w3sf_pkg::LEVEL_W-1:0], s1_q.level};
  assign byp_d     = s1_adv && (col_cur == s1_q.col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_accept) begin
      byp_q <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byp_data_q <= ram_wdata;
    end
  end

  w3sf_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (w3sf_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.col),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  // Window and kernel; the smoothed value reflects the window after shift.
  w3sf_pkg::win_col_t win_col;
  w3sf_pkg::level_t   smoothed;

  assign win_col.top = up_pair[PAIR_W-1:w3sf_pkg::LEVEL_W];
  assign win_col.mid = up_pair[w3sf_pkg::LEVEL_W-1:0];
  assign win_col.bot = s1_q.level;

  w3sf_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_adv),
    .col_i   (win_col),
    .level_o (smoothed)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_q.produce) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_q.produce) begin
      out_q.smoothed_level <= smoothed;
      out_q.last_of_frame  <= s1_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Every accepted transaction is held in the read stage on the next cycle.
  `W3SF_ASSERT_NEXT(a_accept_fills_stage, in_accept, s1_valid_q, "accepted item lost")
  // The bypass is only armed when the held sample wrote the line store.
  `W3SF_ASSERT_NOW(a_bypass_after_write, byp_q && s1_valid_q, $past(s1_adv), "stale bypass")
  // A frame start always places its sample in column zero.
  `W3SF_ASSERT_NEXT(a_frame_start_col, in_accept && in_data_i.frame_start,
                    s1_q.col == '0, "frame start column")
  // A result never overwrites an output that is still stalled.
  `W3SF_ASSERT_NEXT(a_no_overwrite,
                    out_valid_q && out_stall_i && !(s1_valid_q && s1_q.produce),
                    out_valid_q && $stable(out_q), "output overwritten")

endmodule
